[sv/gnfc_pkg.sv]
// shared types, constants and step tables for the nearest free cell search block
package gnfc_pkg;

    localparam int POS_W       = 8;
    localparam int TILE_W      = 2;
    localparam int CELL_W      = 6;
    localparam int DIM_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_W     = 10;
    localparam int ENTRY_W     = TILE_W + 1;
    localparam int VIS_BIT     = TILE_W;
    localparam int NUM_STEPS   = 4;

    localparam logic [DIM_W-1:0]     MAP_DIM_RESET  = 7'd64;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic                 OP_WRITE       = 1'b0;
    localparam logic                 OP_SEARCH      = 1'b1;
    localparam logic [TILE_W-1:0]    TILE_EMPTY     = 2'd0;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXPAND,
        ST_POP,
        ST_DEQ,
        ST_CLEAN,
        ST_DONE
    } gnfc_state_t;

    typedef struct packed {
        logic                    op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [TILE_W-1:0]       tile_code;
    } gnfc_req_t;

    typedef struct packed {
        logic              found;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
    } gnfc_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } gnfc_status_t;

    // neighbour order +x, -x, +y, -y
    function automatic logic signed [COORD_W-1:0] step_dx(input logic [1:0] dir);
        case (dir)
            2'd0:    step_dx = COORD_W'(1);
            2'd1:    step_dx = '1;
            default: step_dx = '0;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] step_dy(input logic [1:0] dir);
        case (dir)
            2'd2:    step_dy = COORD_W'(1);
            2'd3:    step_dy = '1;
            default: step_dy = '0;
        endcase
    endfunction

endpackage

[sv/gnfc_channels.sv]
// valid/ready channel interfaces for items, results and register writes
interface gnfc_item_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     op;
    logic signed [gnfc_pkg::POS_W-1:0]        pos_x;
    logic signed [gnfc_pkg::POS_W-1:0]        pos_y;
    logic [gnfc_pkg::TILE_W-1:0]              tile_code;

    modport source (output valid, op, pos_x, pos_y, tile_code, input ready);
    modport sink (input valid, op, pos_x, pos_y, tile_code, output ready);
endinterface

interface gnfc_result_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [gnfc_pkg::CELL_W-1:0]       cell_x;
    logic [gnfc_pkg::CELL_W-1:0]       cell_y;

    modport source (output valid, found, cell_x, cell_y, input ready);
    modport sink (input valid, found, cell_x, cell_y, output ready);
endinterface

interface gnfc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gnfc_pkg::CFG_IDX_W-1:0]    index;
    logic [gnfc_pkg::DIM_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/gnfc_ram.sv]
// simple dual-port synchronous ram, one write and one registered read per cycle
module gnfc_ram #(
    parameter int DATA_W = 3,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/gnfc_walker.sv]
// breadth-first walk sequencer over the cell ram and the cell queue ram
module gnfc_walker #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  gnfc_pkg::gnfc_req_t            req,
    input  logic [gnfc_pkg::DIM_W-1:0]     eff_w,
    input  logic [gnfc_pkg::DIM_W-1:0]     eff_h,
    input  logic                           out_free,
    output gnfc_pkg::gnfc_status_t         status,
    output gnfc_pkg::gnfc_result_t         res
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int QW  = gnfc_pkg::TILE_W + AW;
    localparam int CW  = gnfc_pkg::COORD_W;
    localparam int TW  = gnfc_pkg::TILE_W;
    localparam int EW  = gnfc_pkg::ENTRY_W;

    function automatic logic in_map(
        input logic signed [CW-1:0]        x,
        input logic signed [CW-1:0]        y,
        input logic [gnfc_pkg::DIM_W-1:0]  w,
        input logic [gnfc_pkg::DIM_W-1:0]  h
    );
        logic signed [CW-1:0] ws;
        logic signed [CW-1:0] hs;
        ws = $signed(CW'(w));
        hs = $signed(CW'(h));
        return !x[CW-1] && !y[CW-1] && (x < ws) && (y < hs);
    endfunction

    gnfc_pkg::gnfc_state_t  state_reg, state_next;
    logic [AW:0]            head_reg, head_next;
    logic [AW:0]            tail_reg, tail_next;
    logic signed [CW-1:0]   base_x_reg, base_x_next;
    logic signed [CW-1:0]   base_y_reg, base_y_next;
    logic                   center_reg, center_next;
    logic [2:0]             dir_reg, dir_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic                   clean_valid_reg, clean_valid_next;
    gnfc_pkg::gnfc_result_t res_reg, res_next;

    logic                   cell_we;
    logic [AW-1:0]          cell_waddr;
    logic [EW-1:0]          cell_wdata;
    logic                   cell_re;
    logic [AW-1:0]          cell_raddr;
    logic [EW-1:0]          cell_rdata;
    logic                   q_we;
    logic [AW-1:0]          q_waddr;
    logic [QW-1:0]          q_wdata;
    logic                   q_re;
    logic [AW-1:0]          q_raddr;
    logic [QW-1:0]          q_rdata;

    logic signed [CW-1:0]   ctr_x;
    logic signed [CW-1:0]   ctr_y;
    logic                   ctr_in;
    logic [AW-1:0]          ctr_addr;
    logic [2:0]             dir_last;
    logic                   issuing;
    logic signed [CW-1:0]   nb_x;
    logic signed [CW-1:0]   nb_y;
    logic                   nb_in;
    logic [AW-1:0]          nb_addr;
    logic                   q_empty;
    logic [TW-1:0]          deq_tile;
    logic [AW-1:0]          deq_addr;
    logic                   pend_push;

    gnfc_ram #(.DATA_W(EW), .ADDR_W(AW)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gnfc_ram #(.DATA_W(QW), .ADDR_W(AW)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign ctr_x    = {{(CW - gnfc_pkg::POS_W){req.pos_x[gnfc_pkg::POS_W-1]}}, req.pos_x};
    assign ctr_y    = {{(CW - gnfc_pkg::POS_W){req.pos_y[gnfc_pkg::POS_W-1]}}, req.pos_y};
    assign ctr_in   = in_map(ctr_x, ctr_y, eff_w, eff_h);
    assign ctr_addr = {ctr_y[YW-1:0], ctr_x[XW-1:0]};

    // an in-map centre is queued alone, otherwise its four neighbours
    assign dir_last = center_reg ? 3'd1 : 3'(gnfc_pkg::NUM_STEPS);
    assign issuing  = dir_reg < dir_last;
    assign nb_x     = base_x_reg + (center_reg ? '0 : gnfc_pkg::step_dx(dir_reg[1:0]));
    assign nb_y     = base_y_reg + (center_reg ? '0 : gnfc_pkg::step_dy(dir_reg[1:0]));
    assign nb_in    = in_map(nb_x, nb_y, eff_w, eff_h);
    assign nb_addr  = {nb_y[YW-1:0], nb_x[XW-1:0]};

    assign q_empty   = head_reg == tail_reg;
    assign deq_tile  = q_rdata[QW-1 -: TW];
    assign deq_addr  = q_rdata[AW-1:0];
    assign pend_push = pend_valid_reg && !cell_rdata[gnfc_pkg::VIS_BIT];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gnfc_pkg::ST_INIT:
            begin
                if (&head_reg[AW-1:0])
                begin
                    state_next = gnfc_pkg::ST_IDLE;
                end
            end
            gnfc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.op == gnfc_pkg::OP_SEARCH) ? gnfc_pkg::ST_EXPAND
                                                                 : gnfc_pkg::ST_DONE;
                end
            end
            gnfc_pkg::ST_EXPAND:
            begin
                if (!issuing)
                begin
                    state_next = gnfc_pkg::ST_POP;
                end
            end
            gnfc_pkg::ST_POP:
            begin
                state_next = q_empty ? gnfc_pkg::ST_CLEAN : gnfc_pkg::ST_DEQ;
            end
            gnfc_pkg::ST_DEQ:
            begin
                state_next = (deq_tile == gnfc_pkg::TILE_EMPTY) ? gnfc_pkg::ST_CLEAN
                                                                : gnfc_pkg::ST_EXPAND;
            end
            gnfc_pkg::ST_CLEAN:
            begin
                if (q_empty && !clean_valid_reg)
                begin
                    state_next = gnfc_pkg::ST_DONE;
                end
            end
            gnfc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = gnfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gnfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        base_x_next      = base_x_reg;
        base_y_next      = base_y_reg;
        center_next      = center_reg;
        dir_next         = dir_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        clean_valid_next = 1'b0;
        res_next         = res_reg;
        cell_we          = 1'b0;
        cell_waddr       = pend_addr_reg;
        cell_wdata       = '0;
        cell_re          = 1'b0;
        cell_raddr       = nb_addr;
        q_we             = 1'b0;
        q_waddr          = tail_reg[AW-1:0];
        q_wdata          = {cell_rdata[TW-1:0], pend_addr_reg};
        q_re             = 1'b0;
        q_raddr          = head_reg[AW-1:0];
        case (state_reg)
            gnfc_pkg::ST_INIT:
            begin
                // clearing pass over the whole cell ram
                cell_we    = 1'b1;
                cell_waddr = head_reg[AW-1:0];
                head_next  = (&head_reg[AW-1:0]) ? '0 : head_reg + 1'b1;
            end
            gnfc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    res_next        = '0;
                    head_next       = '0;
                    tail_next       = '0;
                    base_x_next     = ctr_x;
                    base_y_next     = ctr_y;
                    center_next     = ctr_in;
                    dir_next        = '0;
                    pend_valid_next = 1'b0;
                    if (req.op == gnfc_pkg::OP_WRITE && ctr_in)
                    begin
                        cell_we    = 1'b1;
                        cell_waddr = ctr_addr;
                        cell_wdata = {1'b0, req.tile_code};
                    end
                end
            end
            gnfc_pkg::ST_EXPAND:
            begin
                pend_valid_next = 1'b0;
                if (issuing)
                begin
                    cell_re         = nb_in;
                    pend_valid_next = nb_in;
                    pend_addr_next  = nb_addr;
                    dir_next        = dir_reg + 1'b1;
                end
                // mark visited and queue the neighbour read last cycle
                if (pend_push)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = pend_addr_reg;
                    cell_wdata = {1'b1, cell_rdata[TW-1:0]};
                    q_we       = 1'b1;
                    tail_next  = tail_reg + 1'b1;
                end
            end
            gnfc_pkg::ST_POP:
            begin
                if (q_empty)
                begin
                    head_next = '0;
                end
                else
                begin
                    q_re      = 1'b1;
                    head_next = head_reg + 1'b1;
                end
            end
            gnfc_pkg::ST_DEQ:
            begin
                if (deq_tile == gnfc_pkg::TILE_EMPTY)
                begin
                    res_next.found  = 1'b1;
                    res_next.cell_x = gnfc_pkg::CELL_W'(deq_addr[XW-1:0]);
                    res_next.cell_y = gnfc_pkg::CELL_W'(deq_addr[AW-1:XW]);
                    head_next       = '0;
                end
                else
                begin
                    base_x_next     = $signed(CW'(deq_addr[XW-1:0]));
                    base_y_next     = $signed(CW'(deq_addr[AW-1:XW]));
                    center_next     = 1'b0;
                    dir_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            gnfc_pkg::ST_CLEAN:
            begin
                // every queued cell is exactly a visited cell
                if (!q_empty)
                begin
                    q_re             = 1'b1;
                    head_next        = head_reg + 1'b1;
                    clean_valid_next = 1'b1;
                end
                if (clean_valid_reg)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = deq_addr;
                    cell_wdata = {1'b0, deq_tile};
                end
            end
            gnfc_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gnfc_pkg::ST_INIT;
            head_reg        <= '0;
            tail_reg        <= '0;
            center_reg      <= 1'b0;
            dir_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            clean_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            center_reg      <= center_next;
            dir_reg         <= dir_next;
            pend_valid_reg  <= pend_valid_next;
            clean_valid_reg <= clean_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_x_reg    <= base_x_next;
        base_y_reg    <= base_y_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    assign status.idle = state_reg == gnfc_pkg::ST_IDLE;
    assign status.done = state_reg == gnfc_pkg::ST_DONE;
    assign res         = res_reg;

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gnfc_pkg::ST_INIT) |-> (head_reg <= tail_reg))
        else $error("queue head passed tail");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_we |-> !tail_reg[AW])
        else $error("push into a full cell queue");

    a_clean_only: assert property (@(posedge clk) disable iff (!rst_n)
        clean_valid_reg |-> (state_reg == gnfc_pkg::ST_CLEAN))
        else $error("visited clear pending outside the clean sweep");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gnfc_pkg::ST_DONE) |-> (head_reg == tail_reg))
        else $error("result offered before visited bits were cleared");

    a_start_path: assert property (@(posedge clk) disable iff (!rst_n)
        (status.idle && start) |=>
            (state_reg == gnfc_pkg::ST_EXPAND || state_reg == gnfc_pkg::ST_DONE))
        else $error("accepted transaction not started");

endmodule

[sv/grid_nearest_free_cell_bfs.sv]
// Top level of the nearest free cell search. The block keeps a grid of 2-bit
// tile codes in a cell ram, each entry with a visited flag beside the code, and
// a second ram that serves as the breadth-first cell queue. After reset a
// clearing pass writes every cell ram entry; no transaction is taken meanwhile,
// register writes are. A search queues an in-map centre, or checks the four
// neighbours of a centre off the map, then dequeues cells; each one that is not
// free costs one queue read, one check, four neighbour reads pipelined against
// their read-modify-write and one drain step. When a free cell is dequeued or
// the queue runs empty, the visited flag of every queued cell is cleared again
// and the result is handed over. A finished result sits in an output
// register, so the next transaction can be accepted while it waits.
module grid_nearest_free_cell_bfs #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    gnfc_item_if.sink     item,
    gnfc_result_if.source result,
    gnfc_cfg_if.sink      cfg
);

    logic [gnfc_pkg::DIM_W-1:0] map_width_reg, map_width_next;
    logic [gnfc_pkg::DIM_W-1:0] map_height_reg, map_height_next;
    logic [gnfc_pkg::DIM_W-1:0] eff_w;
    logic [gnfc_pkg::DIM_W-1:0] eff_h;
    logic                       out_valid_reg, out_valid_next;
    gnfc_pkg::gnfc_result_t     out_res_reg, out_res_next;
    gnfc_pkg::gnfc_req_t        req;
    gnfc_pkg::gnfc_status_t     status;
    gnfc_pkg::gnfc_result_t     walk_res;
    logic                       start;
    logic                       out_free;
    logic                       load;

    assign eff_w = (int'(map_width_reg) > MAX_WIDTH) ? gnfc_pkg::DIM_W'(MAX_WIDTH)
                                                     : map_width_reg;
    assign eff_h = (int'(map_height_reg) > MAX_HEIGHT) ? gnfc_pkg::DIM_W'(MAX_HEIGHT)
                                                       : map_height_reg;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                gnfc_pkg::REG_MAP_WIDTH:  map_width_next  = cfg.data;
                gnfc_pkg::REG_MAP_HEIGHT: map_height_next = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign req.op        = item.op;
    assign req.pos_x     = item.pos_x;
    assign req.pos_y     = item.pos_y;
    assign req.tile_code = item.tile_code;
    assign item.ready    = status.idle;
    assign start         = item.valid && item.ready;

    gnfc_walker #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .out_free (out_free),
        .status   (status),
        .res      (walk_res)
    );

    // output register
    assign out_free = !out_valid_reg || result.ready;
    assign load     = status.done && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = walk_res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= gnfc_pkg::MAP_DIM_RESET;
            map_height_reg <= gnfc_pkg::MAP_DIM_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.found  = out_res_reg.found;
    assign result.cell_x = out_res_reg.cell_x;
    assign result.cell_y = out_res_reg.cell_y;

endmodule
